### design/matrix4_inverse_adjugate_core_assert.svh
// Assertion macros for the 4x4 matrix inverse core.
`ifndef MATRIX4_INVERSE_ADJUGATE_CORE_ASSERT_SVH
`define MATRIX4_INVERSE_ADJUGATE_CORE_ASSERT_SVH
`define M4I_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define M4I_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/m4inv_pkg.sv
// Package: types and constants of the 4x4 matrix inverse core.
package m4inv_pkg;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int N_ELEM         = 16;
    localparam int IDX_W          = 4;

    typedef struct packed {
        logic [IDX_W-1:0]   element_index;
        logic signed [FIELD_W-1:0] element_value;
        logic               last_element;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   out_index;
        logic signed [FIELD_W-1:0] out_value;
        logic signed [FIELD_W-1:0] determinant;
        logic               singular;
        logic               saturated;
        logic               last_result;
    } out_item_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_MIN2    = 4'd1,  // acc2 = a*b
        OP_MIN2S   = 4'd2,  // acc2 -= a*b
        OP_M3ADD   = 4'd3,  // acc3 += product (sign given)
        OP_COFST   = 4'd4,  // store cofactor
        OP_DETACC  = 4'd5,  // det += product
        OP_DIVINIT = 4'd6,
        OP_DIVSTEP = 4'd7,
        OP_EMIT    = 4'd8,
        OP_MULA3   = 4'd9,  // multiplier load: element a, acc2
        OP_MULA4   = 4'd10, // multiplier load: element a, cofactor
        OP_MULSTEP = 4'd11  // one 32-bit limb of the product
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] ia;     // element index a
        logic [3:0] ib;     // element index b
        logic [3:0] ic;     // cofactor index
        logic       neg;    // subtract in acc3 step
        logic       clr;    // clear accumulator first
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
    } sts_t;
endpackage

### design/matrix4_inverse_adjugate_core.sv
// 4x4 matrix inverse by adjugate: elements load one per cycle while idle; the
// element marked last starts an inversion. The shared multiplier walks the wide
// operand in NL = ceil((3*DATA_WIDTH+4)/32) limbs of 32 bits for each of the 16
// cofactors and the four determinant products; then each output element takes a
// restoring divide of 3*DATA_WIDTH+4+2*FRAC_BITS quotient bits. busy is high for
// the whole inversion; the 16 results leave on a strobe, one transaction each,
// and cannot be stalled.
module matrix4_inverse_adjugate_core #(
    parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = m4inv_pkg::DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  m4inv_pkg::in_item_t  in_item,
    output logic                 strobe,
    output m4inv_pkg::out_item_t out_item
);
    `include "matrix4_inverse_adjugate_core_assert.svh"

    m4inv_pkg::cmd_t cmd;
    m4inv_pkg::sts_t sts;
    logic acc;

    assign acc = start & ~busy;

    m4inv_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .go(acc & in_item.last_element),
        .sts(sts), .cmd(cmd), .busy(busy)
    );

    m4inv_datapath #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .wr_en(acc), .wr_item(in_item),
        .cmd(cmd), .sts(sts), .result_valid(strobe), .result(out_item)
    );

    `M4I_ASSERT_NEXT(a_start_busy, clk, rst_n, acc && in_item.last_element, busy)
    `M4I_ASSERT_IMPL(a_sing_zero, clk, rst_n, strobe && out_item.singular,
        out_item.out_value == '0)
    `M4I_ASSERT_NEXT(a_last_idle, clk, rst_n, strobe && out_item.last_result, !strobe)
endmodule

### design/m4inv_datapath.sv
// Datapath: element store, minor arithmetic, shared divider, output register.
module m4inv_datapath #(
    parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = m4inv_pkg::DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  m4inv_pkg::in_item_t  wr_item,
    input  m4inv_pkg::cmd_t      cmd,
    output m4inv_pkg::sts_t      sts,
    output logic                 result_valid,
    output m4inv_pkg::out_item_t result
);
    localparam int W2 = 2 * DATA_WIDTH + 2;
    localparam int W3 = 3 * DATA_WIDTH + 4;
    localparam int W4 = 4 * DATA_WIDTH + 6;
    localparam int NW = W3 + 2 * FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam int FW = m4inv_pkg::FIELD_W;
    localparam int LW = 32;
    localparam int NL = (W3 + LW - 1) / LW;
    localparam int BW = NL * LW;
    localparam int PW = BW + DATA_WIDTH;
    localparam int MCW = $clog2(NL + 1);

    logic signed [DATA_WIDTH-1:0] mat [m4inv_pkg::N_ELEM];
    logic signed [W3-1:0] cof_reg [m4inv_pkg::N_ELEM];
    logic signed [W2-1:0] acc2_reg;
    logic signed [W3-1:0] acc3_reg;
    logic signed [W4-1:0] det_reg;
    logic [NW-1:0] num_reg, quo_reg;
    logic [W4-1:0] rem_reg;
    logic [W4-1:0] dabs_reg;
    logic [CW-1:0] cnt_reg;
    logic qneg_reg;
    logic signed [FW-1:0] det_out_reg;
    logic det_clip_reg;
    logic [DATA_WIDTH-1:0] mula_reg;
    logic [BW-1:0] mulb_reg;
    logic [PW-1:0] mulp_reg;
    logic mneg_reg;
    logic [MCW-1:0] mcnt_reg;

    logic signed [2*DATA_WIDTH-1:0] prod2;
    logic signed [W3-1:0] prod3;
    logic signed [W4-1:0] prod4;
    logic signed [W4-1:0] det_sh;
    logic [W4-1:0] rem_sh;
    logic signed [NW:0] qs;
    logic [W3-1:0] cabs;
    logic signed [W3-1:0] csel;
    logic signed [DATA_WIDTH-1:0] ea;
    logic signed [W3-1:0] eb;
    logic [DATA_WIDTH+LW-1:0] pp;
    logic signed [PW:0] prod;

    assign prod2 = mat[cmd.ia] * mat[cmd.ib];
    // limb-serial sign-magnitude multiply, most significant limb first
    assign ea = mat[cmd.ia];
    assign eb = (cmd.op == m4inv_pkg::OP_MULA4) ? cof_reg[cmd.ic] : W3'(acc2_reg);
    assign pp = (DATA_WIDTH + LW)'(mula_reg) * (DATA_WIDTH + LW)'(mulb_reg[BW-1 -: LW]);
    assign prod = mneg_reg ? -$signed({1'b0, mulp_reg}) : $signed({1'b0, mulp_reg});
    assign prod3 = W3'(prod);
    assign prod4 = W4'(prod);
    assign det_sh = det_reg >>> (3 * FRAC_BITS);
    assign rem_sh = {rem_reg[W4-2:0], num_reg[NW-1]};
    assign csel = cof_reg[cmd.ic];
    assign cabs = csel[W3-1] ? W3'(-csel) : W3'(csel);
    assign qs = qneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign sts.div_done = (cnt_reg == CW'(NW));
    assign sts.mul_done = (mcnt_reg == MCW'(NL));

    function automatic logic [FW:0] sat_w(input logic signed [W4+NW:0] v);
        logic signed [FW-1:0] mx, mn;
        mx = FW'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
        mn = -mx - 1;
        if (v > (W4 + NW + 1)'(mx)) return {1'b1, mx};
        if (v < (W4 + NW + 1)'(mn)) return {1'b1, mn};
        return {1'b0, FW'(v)};
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mat[wr_item.element_index] <= wr_item.element_value[DATA_WIDTH-1:0];
        end
        case (cmd.op)
            m4inv_pkg::OP_MIN2:  acc2_reg <= W2'(prod2);
            m4inv_pkg::OP_MIN2S: acc2_reg <= acc2_reg - W2'(prod2);
            m4inv_pkg::OP_MULA3, m4inv_pkg::OP_MULA4:
            begin
                mula_reg <= ea[DATA_WIDTH-1] ? DATA_WIDTH'(-ea) : DATA_WIDTH'(ea);
                mulb_reg <= BW'($unsigned(eb[W3-1] ? W3'(-eb) : W3'(eb)));
                mulp_reg <= '0;
                mneg_reg <= ea[DATA_WIDTH-1] ^ eb[W3-1];
                mcnt_reg <= '0;
            end
            m4inv_pkg::OP_MULSTEP:
            begin
                mulp_reg <= (mulp_reg << LW) + PW'(pp);
                mulb_reg <= mulb_reg << LW;
                mcnt_reg <= mcnt_reg + MCW'(1);
            end
            m4inv_pkg::OP_M3ADD:
            begin
                if (cmd.clr)
                    acc3_reg <= cmd.neg ? -prod3 : prod3;
                else
                    acc3_reg <= cmd.neg ? acc3_reg - prod3 : acc3_reg + prod3;
            end
            m4inv_pkg::OP_COFST: cof_reg[cmd.ic] <= cmd.neg ? -acc3_reg : acc3_reg;
            m4inv_pkg::OP_DETACC:
            begin
                det_reg <= cmd.clr ? prod4 : det_reg + prod4;
            end
            m4inv_pkg::OP_DIVINIT:
            begin
                num_reg <= NW'(cabs) << (2 * FRAC_BITS);
                quo_reg <= '0;
                rem_reg <= '0;
                cnt_reg <= '0;
                qneg_reg <= csel[W3-1] ^ det_reg[W4-1];
                dabs_reg <= det_reg[W4-1] ? W4'(-det_reg) : W4'(det_reg);
                {det_clip_reg, det_out_reg} <= sat_w((W4 + NW + 1)'(det_sh));
            end
            m4inv_pkg::OP_DIVSTEP:
            begin
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg + CW'(1);
                if (rem_sh >= dabs_reg)
                begin
                    rem_reg <= rem_sh - dabs_reg;
                    quo_reg <= {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[NW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= (cmd.op == m4inv_pkg::OP_EMIT);
    end

    logic [FW:0] vsat;
    logic sing;
    assign vsat = sat_w((W4 + NW + 1)'(qs));
    assign sing = (det_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.op == m4inv_pkg::OP_EMIT)
        begin
            result.out_index   <= cmd.ib;
            result.out_value   <= sing ? '0 : vsat[FW-1:0];
            result.determinant <= det_out_reg;
            result.singular    <= sing;
            result.saturated   <= det_clip_reg | (!sing & vsat[FW]);
            result.last_result <= (cmd.ib == 4'd15);
        end
    end
endmodule

### design/m4inv_ctrl.sv
// Controller: sequences minors, determinant and divisions.
module m4inv_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  m4inv_pkg::sts_t sts,
    output m4inv_pkg::cmd_t cmd,
    output logic            busy
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MIN  = 8'b00000010,
        S_M3   = 8'b00000100,
        S_DET  = 8'b00001000,
        S_DM   = 8'b00010000,
        S_DINI = 8'b00100000,
        S_DIV  = 8'b01000000,
        S_EMIT = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] k_reg, k_next;    // cofactor / output index
    logic [3:0] s_reg, s_next;    // step within a cofactor

    logic [1:0] row, col;
    logic [1:0] rs [3];
    logic [1:0] cs [3];
    logic [1:0] j, ja, jb, ph;

    always_comb
    begin
        row = k_reg[3:2];
        col = k_reg[1:0];
        for (int t = 0; t < 3; t++)
        begin
            rs[t] = 2'(t) + ((2'(t) >= row) ? 2'd1 : 2'd0);
            cs[t] = 2'(t) + ((2'(t) >= col) ? 2'd1 : 2'd0);
        end
    end

    // 3 terms x (2 products + 1 accumulate) = 9 steps, then store
    always_comb
    begin
        case (s_reg)
            4'd0, 4'd1, 4'd2: j = 2'd0;
            4'd3, 4'd4, 4'd5: j = 2'd1;
            default:          j = 2'd2;
        endcase
        case (s_reg)
            4'd0, 4'd3, 4'd6: ph = 2'd0;
            4'd1, 4'd4, 4'd7: ph = 2'd1;
            default:          ph = 2'd2;
        endcase
        ja = (j == 2'd0) ? 2'd1 : 2'd0;
        jb = (j == 2'd2) ? 2'd1 : 2'd2;
        cmd = '0;
        busy = (state_reg != S_IDLE);
        state_next = state_reg;
        k_next = k_reg;
        s_next = s_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next = S_MIN;
                    k_next = '0;
                    s_next = '0;
                end
            end
            S_MIN:
            begin
                s_next = s_reg + 4'd1;
                if (s_reg == 4'd9)
                begin
                    cmd.op = m4inv_pkg::OP_COFST;
                    cmd.ic = k_reg;
                    cmd.neg = row[0] ^ col[0];
                    s_next = '0;
                    k_next = k_reg + 4'd1;
                    if (k_reg == 4'd15)
                        state_next = S_DET;
                end
                else
                begin
                    case (ph)
                        2'd0:
                        begin
                            cmd.op = m4inv_pkg::OP_MIN2;
                            cmd.ia = {rs[1], cs[ja]};
                            cmd.ib = {rs[2], cs[jb]};
                        end
                        2'd1:
                        begin
                            cmd.op = m4inv_pkg::OP_MIN2S;
                            cmd.ia = {rs[1], cs[jb]};
                            cmd.ib = {rs[2], cs[ja]};
                        end
                        default:
                        begin
                            cmd.op = m4inv_pkg::OP_MULA3;
                            cmd.ia = {rs[0], cs[j]};
                            s_next = s_reg;
                            state_next = S_M3;
                        end
                    endcase
                end
            end
            S_M3:
            begin
                if (sts.mul_done)
                begin
                    cmd.op = m4inv_pkg::OP_M3ADD;
                    cmd.neg = (j == 2'd1);
                    cmd.clr = (j == 2'd0);
                    s_next = s_reg + 4'd1;
                    state_next = S_MIN;
                end
                else
                    cmd.op = m4inv_pkg::OP_MULSTEP;
            end
            S_DET:
            begin
                cmd.op = m4inv_pkg::OP_MULA4;
                cmd.ia = s_reg;
                cmd.ic = s_reg;
                state_next = S_DM;
            end
            S_DM:
            begin
                if (sts.mul_done)
                begin
                    cmd.op = m4inv_pkg::OP_DETACC;
                    cmd.clr = (s_reg == 4'd0);
                    s_next = s_reg + 4'd1;
                    state_next = S_DET;
                    if (s_reg == 4'd3)
                    begin
                        s_next = '0;
                        k_next = '0;
                        state_next = S_DINI;
                    end
                end
                else
                    cmd.op = m4inv_pkg::OP_MULSTEP;
            end
            S_DINI:
            begin
                cmd.op = m4inv_pkg::OP_DIVINIT;
                cmd.ic = {k_reg[1:0], k_reg[3:2]};
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_EMIT;
                else
                    cmd.op = m4inv_pkg::OP_DIVSTEP;
            end
            S_EMIT:
            begin
                cmd.op = m4inv_pkg::OP_EMIT;
                cmd.ib = k_reg;
                k_next = k_reg + 4'd1;
                state_next = (k_reg == 4'd15) ? S_IDLE : S_DINI;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg <= '0;
            s_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            s_reg <= s_next;
        end
    end
endmodule

### bench/tb_matrix4_inverse_adjugate_core.sv
// Testbench for the 4x4 matrix inverse core: loads matrices, predicts the inverse, checks each result.
class inverse_scoreboard;
    typedef logic signed [255:0] wide_t;

    bit [31:0] elem_store [16];
    m4inv_pkg::out_item_t pending_q [$];
    int errors;

    function wide_t ext(bit [31:0] x);
        wide_t w;
        w = $signed(x);
        return w;
    endfunction

    function wide_t cofactor(int row, int col);
        wide_t m [3][3];
        wide_t d;
        int rr;
        int cc;
        rr = 0;
        for (int r = 0; r < 4; r++)
        begin
            if (r == row)
                continue;
            cc = 0;
            for (int c = 0; c < 4; c++)
            begin
                if (c == col)
                    continue;
                m[rr][cc] = ext(elem_store[r * 4 + c]);
                cc++;
            end
            rr++;
        end
        d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
          - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
          + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
        return ((row + col) % 2 == 1) ? -d : d;
    endfunction

    function bit [31:0] clip32(wide_t v, inout bit clipped);
        wide_t hi;
        wide_t lo;
        hi = 64'sh7fffffff;
        lo = -64'sh80000000;
        if (v > hi)
        begin
            clipped = 1'b1;
            return 32'h7fffffff;
        end
        if (v < lo)
        begin
            clipped = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function void note_input(m4inv_pkg::in_item_t it);
        wide_t cof [16];
        wide_t det;
        wide_t q;
        bit det_clip;
        bit clip;
        bit [31:0] det_out;
        m4inv_pkg::out_item_t r;
        elem_store[it.element_index] = it.element_value;
        if (!it.last_element)
            return;
        for (int k = 0; k < 16; k++)
            cof[k] = cofactor(k / 4, k % 4);
        det = 0;
        for (int k = 0; k < 4; k++)
            det = det + ext(elem_store[k]) * cof[k];
        det_clip = 1'b0;
        det_out = clip32(det >>> 48, det_clip);
        for (int k = 0; k < 16; k++)
        begin
            clip = det_clip;
            r = '0;
            r.out_index = 4'(k);
            r.determinant = det_out;
            r.last_result = (k == 15);
            if (det == 0)
            begin
                r.singular = 1'b1;
                r.out_value = '0;
            end
            else
            begin
                q = (cof[(k % 4) * 4 + k / 4] <<< 32) / det;
                r.out_value = clip32(q, clip);
            end
            r.saturated = clip;
            pending_q.push_back(r);
        end
    endfunction

    function void check(m4inv_pkg::out_item_t got);
        m4inv_pkg::out_item_t exp_r;
        if (pending_q.size() == 0)
        begin
            $display("%0t unexpected transaction: expected none, actual %h", $realtime, got);
            errors++;
            return;
        end
        exp_r = pending_q.pop_front();
        if (got.out_index !== exp_r.out_index)
        begin
            $display("%0t out_index: expected %0d, actual %0d", $realtime,
                     exp_r.out_index, got.out_index);
            errors++;
        end
        if (got.out_value !== exp_r.out_value)
        begin
            $display("%0t out_value[%0d]: expected %h, actual %h", $realtime,
                     exp_r.out_index, exp_r.out_value, got.out_value);
            errors++;
        end
        if (got.determinant !== exp_r.determinant)
        begin
            $display("%0t determinant: expected %h, actual %h", $realtime,
                     exp_r.determinant, got.determinant);
            errors++;
        end
        if (got.singular !== exp_r.singular)
        begin
            $display("%0t singular: expected %b, actual %b", $realtime,
                     exp_r.singular, got.singular);
            errors++;
        end
        if (got.saturated !== exp_r.saturated)
        begin
            $display("%0t saturated[%0d]: expected %b, actual %b", $realtime,
                     exp_r.out_index, exp_r.saturated, got.saturated);
            errors++;
        end
        if (got.last_result !== exp_r.last_result)
        begin
            $display("%0t last_result: expected %b, actual %b", $realtime,
                     exp_r.last_result, got.last_result);
            errors++;
        end
    endfunction
endclass

module tb_matrix4_inverse_adjugate_core;
    timeunit 1ns;
    timeprecision 1ps;

    import m4inv_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_item_t in_item;
    logic strobe;
    out_item_t out_item;

    inverse_scoreboard sb;
    int cycles;
    int sent;
    bit quiet;
    bit [31:0] row_copy [4];

    matrix4_inverse_adjugate_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .in_item(in_item),
        .strobe(strobe),
        .out_item(out_item)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
        if (rst_n && strobe && sb != null)
            sb.check(out_item);

    task automatic send(input logic [3:0] idx, input logic [31:0] val, input logic last);
        in_item_t it;
        it.element_index = idx;
        it.element_value = val;
        it.last_element = last;
        start <= 1'b1;
        in_item <= it;
        @(negedge clk);
        while (busy)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        sb.note_input(it);
        sent++;
        if (!quiet && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            in_item <= '0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_elem(int kind, int idx);
        case (kind)
            0: return $urandom();
            1: return ((idx % 5) == 0) ? 32'($urandom_range(32'h10000, 32'h40000))
                                     : 32'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
            2: return 32'($signed($urandom_range(0, 32'h200000)) - 32'sh100000);
            default: return 32'($signed($urandom_range(0, 32'h2000000)) - 32'sh1000000);
        endcase
    endfunction

    task automatic load_matrix(input int kind, input bit make_singular);
        int order [16];
        int j;
        int t;
        logic [31:0] v [16];
        for (int k = 0; k < 16; k++)
        begin
            order[k] = k;
            v[k] = rand_elem(kind, k);
        end
        if (make_singular)
        begin
            j = $urandom_range(1, 3);
            for (int c = 0; c < 4; c++)
                v[j * 4 + c] = v[c];
        end
        for (int k = 15; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (int k = 0; k < 16; k++)
            send(4'(order[k]), v[order[k]], k == 15);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        in_item <= '0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic j_row_copy();
        int r;
        r = $urandom_range(1, 3);
        for (int c = 0; c < 4; c++)
            row_copy[c] = sb.elem_store[c];
        for (int c = 0; c < 4; c++)
            send(4'(r * 4 + c), row_copy[c], c == 3);
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        sent = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity
        for (int k = 0; k < 16; k++)
            send(4'(k), (k % 5 == 0) ? 32'h00010000 : 32'h0, k == 15);
        // extreme values, overflow
        send(4'd0, 32'h80000000, 1'b0);
        send(4'd15, 32'h7fffffff, 1'b1);
        // zero row and column: singular
        send(4'd0, 32'h0, 1'b0);
        send(4'd5, 32'h0, 1'b1);
        // restore a small diagonal, stale entries elsewhere
        send(4'd0, 32'h00020000, 1'b0);
        send(4'd5, 32'hffff0000, 1'b1);

        while (sent < 270)
        begin
            quiet = (sent > 110 && sent < 190);
            case ($urandom_range(9))
                0, 1, 2, 3: load_matrix($urandom_range(1, 3), 1'b0);
                4: load_matrix(0, 1'b0);
                5: load_matrix($urandom_range(0, 3), 1'b1);
                6:
                begin
                    // stale reload: a few entries, then invert
                    repeat ($urandom_range(0, 3))
                        send(4'($urandom_range(15)), rand_elem($urandom_range(1, 3), 5),
                             1'b0);
                    send(4'($urandom_range(15)), rand_elem(2, 0), 1'b1);
                end
                7:
                begin
                    // copied row after stale state, singular
                    j_row_copy();
                end
                default:
                begin
                    send(4'($urandom_range(15)), $urandom(), 1'b0);
                    send(4'($urandom_range(15)), rand_elem(1, 0), 1'b0);
                end
            endcase
            if ($urandom_range(19) == 0)
                wait_drained();
        end
        wait_drained();
        repeat (4000) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
